// ===== src/sct_pkg.sv =====
// sct_pkg: item, result and table entry types for the shrinking circle table.
// No dependencies; imported by shrinking_circle_table and its testbench.
package sct_pkg;

    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    localparam int unsigned LifeReset = 196608;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_z;
        logic [23:0]        circle_radius;
        logic [15:0]        time_step;
    } cmd_t;

    typedef struct packed {
        logic       accepted;
        logic       overlaps;
        logic [4:0] live_count;
    } result_t;

    // one stored circle; a tick keeps only circles whose life stays positive
    typedef struct packed {
        logic signed [23:0] cx;
        logic signed [23:0] cz;
        logic [23:0]        cur_rad;
        logic [23:0]        start_rad;
        logic [31:0]        life;
    } entry_t;

endpackage

// ===== src/shrinking_circle_table.sv =====
// shrinking_circle_table: circle table with add, tick (shrink/expire/compact) and query.
// Depends on sct_pkg; one table memory, one shared 32x32 multiplier, a bit-serial divider.
//
//  channel | ports                         | handshake
//  --------+-------------------------------+---------------------------------
//  command | start, busy, cmd              | taken when start && !busy
//  result  | done, result                  | one-cycle strobe, no back pressure
//  config  | cfg_valid, cfg_ready, cfg_data| written when cfg_valid && cfg_ready
//
// Add and no-op items finish in the idle state; done follows on the next cycle.
// A tick drops each expired circle, writes back one clamped to its start radius, and for
// a shrinking one does one multiply plus 24 divider steps on the shared unit. A query does
// three multiplies per circle through the one multiplier, stopping at the first hit.
// rst_n clears the count and loads max_lifetime with 3.0 s; table entries are not cleared.
// The result cannot be stalled; the next item may start while done is high.
module shrinking_circle_table
    import sct_pkg::*;
#(
    parameter int MAX_HOLES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  cmd_t        cmd,
    output logic        done,
    output result_t     result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    localparam int IDX_W = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
    localparam int CNT_W = $clog2(MAX_HOLES + 1);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_FETCH = 11'b000_0000_0010,
        S_LOAD  = 11'b000_0000_0100,
        S_TMUL  = 11'b000_0000_1000,
        S_TDIVI = 11'b000_0001_0000,
        S_TDIV  = 11'b000_0010_0000,
        S_TWR   = 11'b000_0100_0000,
        S_QMX   = 11'b000_1000_0000,
        S_QMZ   = 11'b001_0000_0000,
        S_QMR   = 11'b010_0000_0000,
        S_QCMP  = 11'b100_0000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   kept_reg, kept_next;
    logic [31:0]        max_reg;
    cmd_t               probe_reg, probe_next;
    entry_t             ent_reg, ent_next;
    logic signed [32:0] life_reg, life_next;
    logic [31:0]        rem_reg, rem_next;
    logic [23:0]        quo_reg, quo_next;
    logic [4:0]         step_reg, step_next;
    logic [24:0]        ux_reg, ux_next, uz_reg, uz_next, rr_reg, rr_next;
    logic [50:0]        acc_reg, acc_next;
    logic [63:0]        prod_reg;
    logic [31:0]        mul_a, mul_b;
    logic               done_reg, done_next;
    result_t            res_reg, res_next;

    entry_t             mem [MAX_HOLES];
    entry_t             rd_data_reg;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;

    logic               adv;
    logic [32:0]        rem2;
    logic               ge;
    logic signed [24:0] dx, dz;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = !busy;
    assign done      = done_reg;
    assign result    = res_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[idx_reg[IDX_W-1:0]];
        prod_reg    <= 64'(mul_a) * 64'(mul_b);
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        kept_next  = kept_reg;
        probe_next = probe_reg;
        ent_next   = ent_reg;
        life_next  = life_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;
        ux_next    = ux_reg;
        uz_next    = uz_reg;
        rr_next    = rr_reg;
        acc_next   = acc_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        wr_en      = 1'b0;
        wr_addr    = kept_reg[IDX_W-1:0];
        wr_data    = ent_reg;
        mul_a      = '0;
        mul_b      = '0;
        adv        = 1'b0;
        rem2       = {rem_reg, quo_reg[23]};
        ge         = (rem2 >= {1'b0, max_reg});
        dx         = {probe_reg.pos_x[23], probe_reg.pos_x} - {rd_data_reg.cx[23], rd_data_reg.cx};
        dz         = {probe_reg.pos_z[23], probe_reg.pos_z} - {rd_data_reg.cz[23], rd_data_reg.cz};

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    probe_next = cmd;
                    idx_next   = '0;
                    kept_next  = '0;
                    res_next   = '0;
                    if (cmd.kind == KIND_ADD)
                    begin
                        if (32'(count_reg) < 32'(MAX_HOLES))
                        begin
                            wr_en             = 1'b1;
                            wr_addr           = count_reg[IDX_W-1:0];
                            wr_data.cx        = cmd.pos_x;
                            wr_data.cz        = cmd.pos_z;
                            wr_data.cur_rad   = cmd.circle_radius;
                            wr_data.start_rad = cmd.circle_radius;
                            wr_data.life      = max_reg;
                            count_next        = count_reg + CNT_W'(1);
                            res_next.accepted = 1'b1;
                        end
                        done_next = 1'b1;
                    end
                    else if ((cmd.kind == KIND_TICK || cmd.kind == KIND_QUERY)
                             && count_reg != '0)
                    begin
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                    res_next.live_count = 5'(count_next);
                end
            end
            S_FETCH:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                ent_next = rd_data_reg;
                if (probe_reg.kind == KIND_TICK)
                begin
                    life_next = $signed({1'b0, rd_data_reg.life})
                              - $signed({17'b0, probe_reg.time_step});
                    if (life_next <= 0)
                    begin
                        adv = 1'b1;
                    end
                    else if (life_next >= $signed({1'b0, max_reg}))
                    begin
                        ent_next.cur_rad = rd_data_reg.start_rad;
                        state_next       = S_TWR;
                    end
                    else
                    begin
                        state_next = S_TMUL;
                    end
                end
                else
                begin
                    ux_next    = dx[24] ? 25'(-dx) : 25'(dx);
                    uz_next    = dz[24] ? 25'(-dz) : 25'(dz);
                    rr_next    = 25'(rd_data_reg.cur_rad) + 25'(probe_reg.circle_radius);
                    state_next = S_QMX;
                end
            end
            S_TMUL:
            begin
                mul_a      = 32'(ent_reg.start_rad);
                mul_b      = life_reg[31:0];
                state_next = S_TDIVI;
            end
            S_TDIVI:
            begin
                // life < max, so the quotient fits 24 bits and the top part is below max
                rem_next   = prod_reg[55:24];
                quo_next   = prod_reg[23:0];
                step_next  = '0;
                state_next = S_TDIV;
            end
            S_TDIV:
            begin
                rem_next  = ge ? 32'(rem2 - {1'b0, max_reg}) : rem2[31:0];
                quo_next  = {quo_reg[22:0], ge};
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd23)
                begin
                    ent_next.cur_rad = quo_next;
                    state_next       = S_TWR;
                end
            end
            S_TWR:
            begin
                wr_en        = 1'b1;
                wr_data.life = life_reg[31:0];
                kept_next    = kept_reg + CNT_W'(1);
                adv          = 1'b1;
            end
            S_QMX:
            begin
                mul_a      = 32'(ux_reg);
                mul_b      = 32'(ux_reg);
                state_next = S_QMZ;
            end
            S_QMZ:
            begin
                mul_a      = 32'(uz_reg);
                mul_b      = 32'(uz_reg);
                acc_next   = prod_reg[50:0];
                state_next = S_QMR;
            end
            S_QMR:
            begin
                mul_a      = 32'(rr_reg);
                mul_b      = 32'(rr_reg);
                acc_next   = acc_reg + prod_reg[50:0];
                state_next = S_QCMP;
            end
            S_QCMP:
            begin
                if (acc_reg <= prod_reg[50:0])
                begin
                    res_next.overlaps = 1'b1;
                    done_next         = 1'b1;
                    state_next        = S_IDLE;
                end
                else
                begin
                    adv = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (adv)
        begin
            if (idx_reg + CNT_W'(1) == count_reg)
            begin
                if (probe_reg.kind == KIND_TICK)
                begin
                    count_next = kept_next;
                end
                res_next.live_count = 5'(count_next);
                done_next           = 1'b1;
                state_next          = S_IDLE;
            end
            else
            begin
                idx_next   = idx_reg + CNT_W'(1);
                state_next = S_FETCH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            max_reg   <= LifeReset;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                max_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        kept_reg  <= kept_next;
        probe_reg <= probe_next;
        ent_reg   <= ent_next;
        life_reg  <= life_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        step_reg  <= step_next;
        ux_reg    <= ux_next;
        uz_reg    <= uz_next;
        rr_reg    <= rr_next;
        acc_reg   <= acc_next;
        res_reg   <= res_next;
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == S_IDLE)
        else $error("done strobe while sequencer active");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(MAX_HOLES))
        else $error("circle count beyond table depth");

    a_add_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd.kind == KIND_ADD |=> done && !busy)
        else $error("add item did not finish in one cycle");

    a_acc_only_add: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.accepted |-> $past(state_reg) == S_IDLE && !result.overlaps)
        else $error("accepted flag from a non-add item");

    a_tick_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> kept_reg <= idx_reg + CNT_W'(1))
        else $error("compaction write pointer ran ahead of read pointer");

endmodule

// ===== tb/shrinking_circle_table_tb.sv =====
// shrinking_circle_table_tb: self-checking testbench for the circle table.
// Depends on sct_pkg and shrinking_circle_table. It runs a directed table, then
// random phases across several max_lifetime settings, all checked by a local predictor.
`timescale 1ns / 100ps

module shrinking_circle_table_tb;
    import sct_pkg::*;

    localparam int          TableDepth = 16;
    localparam logic [1:0]  KIND_NOP   = 2'd3;
    localparam int          StallLimit = 5000;

    typedef struct {
        cmd_t    item;
        bit      typed;
        result_t want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    cmd_t        cmd = '0;
    logic        done;
    result_t     result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;

    // local copy of the table
    logic [31:0]        life_max;
    logic signed [23:0] tab_x [TableDepth];
    logic signed [23:0] tab_z [TableDepth];
    logic [23:0]        tab_rad [TableDepth];
    logic [23:0]        tab_start [TableDepth];
    longint             tab_life [TableDepth];
    int                 tab_count;

    result_t pending_results[$];
    bit      failed = 1'b0;
    bit      calm = 1'b0;
    int      quiet_cycles = 0;

    shrinking_circle_table #(.MAX_HOLES(TableDepth)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic logic [23:0] shrunk_radius(logic [23:0] base, longint life);
        logic [63:0] prod;
        if (life <= 0)
            return '0;
        if (64'(life) >= 64'(life_max))
            return base;
        prod = 64'(base) * 64'(life);
        return 24'(prod / 64'(life_max));
    endfunction

    function automatic result_t apply_item(cmd_t c);
        result_t r;
        int      kept;
        longint  life;
        longint  dx;
        longint  dz;
        longint  rr;
        r = '0;
        case (c.kind)
            KIND_ADD:
                if (tab_count < TableDepth)
                begin
                    tab_x[tab_count]     = c.pos_x;
                    tab_z[tab_count]     = c.pos_z;
                    tab_rad[tab_count]   = c.circle_radius;
                    tab_start[tab_count] = c.circle_radius;
                    tab_life[tab_count]  = longint'(life_max);
                    tab_count++;
                    r.accepted = 1'b1;
                end
            KIND_TICK:
            begin
                kept = 0;
                for (int i = 0; i < tab_count; i++)
                begin
                    life = tab_life[i] - longint'(c.time_step);
                    if (life > 0)
                    begin
                        tab_x[kept]     = tab_x[i];
                        tab_z[kept]     = tab_z[i];
                        tab_start[kept] = tab_start[i];
                        tab_rad[kept]   = shrunk_radius(tab_start[i], life);
                        tab_life[kept]  = life;
                        kept++;
                    end
                end
                tab_count = kept;
            end
            KIND_QUERY:
                for (int i = 0; i < tab_count; i++)
                begin
                    dx = longint'(c.pos_x) - longint'(tab_x[i]);
                    dz = longint'(c.pos_z) - longint'(tab_z[i]);
                    rr = longint'(tab_rad[i]) + longint'(c.circle_radius);
                    if (dx * dx + dz * dz <= rr * rr)
                        r.overlaps = 1'b1;
                end
            default: ;
        endcase
        r.live_count = 5'(tab_count);
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with nothing expected: got %p", $realtime, result);
                failed = 1'b1;
            end
            else if (result !== pending_results[0])
            begin
                $display("%0t: result mismatch: expected %p, got %p",
                         $realtime, pending_results[0], result);
                failed = 1'b1;
                void'(pending_results.pop_front());
            end
            else
                void'(pending_results.pop_front());
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (done || (start && !busy) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit)
        begin
            $display("shrinking_circle_table_tb: FAIL");
            $finish;
        end
    end

    // start stays high from one item into the next; it drops only for a gap
    task automatic send_item(cmd_t c, bit typed, result_t want);
        result_t r;
        @(negedge clk);
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        r = apply_item(c);
        pending_results.push_back(typed ? want : r);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_lifetime(logic [31:0] value);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        life_max = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic cmd_t random_item();
        cmd_t c;
        int   pick;
        int   sel;
        c = '0;
        pick = $urandom_range(0, 99);
        c.kind = pick < 35 ? KIND_ADD : pick < 65 ? KIND_TICK :
                 pick < 95 ? KIND_QUERY : KIND_NOP;
        c.time_step = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 20000));
        c.circle_radius = $urandom_range(0, 7) == 0 ? 24'($urandom)
                                                    : 24'($urandom_range(0, 3000));
        if ($urandom_range(0, 7) == 0)
        begin
            c.pos_x = 24'($urandom);
            c.pos_z = 24'($urandom);
        end
        else if (c.kind == KIND_QUERY && tab_count > 0 && $urandom_range(0, 1) == 0)
        begin
            // probe close to a stored circle so hits and near misses both show up
            sel = $urandom_range(0, tab_count - 1);
            c.pos_x = tab_x[sel] + 24'(int'($urandom_range(0, 6000)) - 3000);
            c.pos_z = tab_z[sel] + 24'(int'($urandom_range(0, 6000)) - 3000);
        end
        else
        begin
            c.pos_x = 24'(int'($urandom_range(0, 16000)) - 8000);
            c.pos_z = 24'(int'($urandom_range(0, 16000)) - 8000);
        end
        return c;
    endfunction

    initial
    begin
        row_t        rows[$];
        row_t        rw;
        cmd_t        c;
        logic [31:0] settings[6];

        life_max  = LifeReset;
        tab_count = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table: kind, x, z, radius, step, typed, expected
        rows.push_back('{'{KIND_QUERY, 24'sd0, 24'sd0, 24'hFFFFFF, 16'd0}, 1, '{0, 0, 5'd0}});
        rows.push_back('{'{KIND_TICK, 24'sd0, 24'sd0, 24'd0, 16'hFFFF}, 1, '{0, 0, 5'd0}});
        rows.push_back('{'{KIND_NOP, 24'sd0, 24'sd0, 24'd0, 16'd0}, 1, '{0, 0, 5'd0}});
        rows.push_back('{'{KIND_ADD, 24'sh7FFFFF, 24'sh7FFFFF, 24'hFFFFFF, 16'hFFFF},
                         1, '{1, 0, 5'd1}});
        rows.push_back('{'{KIND_ADD, -24'sh800000, -24'sh800000, 24'd0, 16'd0},
                         1, '{1, 0, 5'd2}});
        rows.push_back('{'{KIND_ADD, 24'sd0, 24'sd0, 24'd256, 16'd0}, 1, '{1, 0, 5'd3}});
        // touching: distance equals the radius sum
        rows.push_back('{'{KIND_QUERY, 24'sd512, 24'sd0, 24'd256, 16'd0}, 0, '0});
        rows.push_back('{'{KIND_QUERY, 24'sd513, 24'sd0, 24'd256, 16'd0}, 0, '0});
        rows.push_back('{'{KIND_QUERY, -24'sh800000, 24'sh7FFFFF, 24'hFFFFFF, 16'd0}, 0, '0});
        rows.push_back('{'{KIND_NOP, 24'sh7FFFFF, -24'sh800000, 24'hFFFFFF, 16'hFFFF},
                         1, '{0, 0, 5'd3}});
        rows.push_back('{'{KIND_TICK, 24'sd0, 24'sd0, 24'd0, 16'd0}, 0, '0});
        rows.push_back('{'{KIND_TICK, 24'sd0, 24'sd0, 24'd0, 16'd1}, 0, '0});
        rows.push_back('{'{KIND_TICK, 24'sd0, 24'sd0, 24'd0, 16'hFFFF}, 0, '0});
        rows.push_back('{'{KIND_QUERY, 24'sd300, 24'sd0, 24'd10, 16'd0}, 0, '0});
        rows.push_back('{'{KIND_TICK, 24'sd0, 24'sd0, 24'd0, 16'hFFFF}, 0, '0});
        rows.push_back('{'{KIND_TICK, 24'sd0, 24'sd0, 24'd0, 16'hFFFF}, 0, '0});
        // two units of life left: this tick brings every circle to exactly zero
        rows.push_back('{'{KIND_TICK, 24'sd0, 24'sd0, 24'd0, 16'd2}, 1, '{0, 0, 5'd0}});
        foreach (rows[i])
            send_item(rows[i].item, rows[i].typed, rows[i].want);

        // fill the table, then one add too many
        for (int i = 0; i <= TableDepth; i++)
        begin
            c = random_item();
            c.kind = KIND_ADD;
            send_item(c, i == TableDepth, '{0, 0, 5'd16});
        end
        // lower the register under live circles: radius clamps to start
        write_lifetime(32'd1000);
        rw.item = '{KIND_TICK, 24'sd0, 24'sd0, 24'd0, 16'd10};
        send_item(rw.item, 0, '0);
        rw.item = '{KIND_QUERY, 24'sd0, 24'sd0, 24'd500, 16'd0};
        send_item(rw.item, 0, '0);

        settings[0] = LifeReset;
        settings[1] = 32'd1;
        settings[2] = 32'hFFFFFFFF;
        settings[3] = 32'd0;
        settings[4] = $urandom_range(2000, 400000);
        settings[5] = 32'd65536;
        foreach (settings[p])
        begin
            write_lifetime(settings[p]);
            calm = (p == 5);
            repeat (105)
            begin
                c = random_item();
                send_item(c, 0, '0);
            end
        end

        drain();
        if (!failed)
            $display("shrinking_circle_table_tb: PASS");
        else
            $display("shrinking_circle_table_tb: FAIL");
        $finish;
    end

endmodule
